// File: rtl/climate_sensor_compensation_defines.svh
// Assertion macros for the compensation block
`ifndef CLIMATE_SENSOR_COMPENSATION_DEFINES_SVH
`define CLIMATE_SENSOR_COMPENSATION_DEFINES_SVH

// same-cycle implication
`define CSC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csc assertion failed");

// next-cycle implication
`define CSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csc assertion failed");

`endif

// File: rtl/csc_pkg.sv
`timescale 1ns / 1ps
package csc_pkg;
	localparam int DIV_W = 32;

	localparam logic [31:0] C_64000   = 32'd64000;
	localparam logic [31:0] C_1M      = 32'd1048576;
	localparam logic [31:0] C_3125    = 32'd3125;
	localparam logic [31:0] C_SIGN    = 32'h8000_0000;
	localparam logic [31:0] C_76800   = 32'd76800;
	localparam logic [31:0] C_HUM_MAX = 32'd419430400;
	localparam logic [31:0] C_2M      = 32'd2097152;
	localparam logic [31:0] C_16384   = 32'd16384;
	localparam logic [31:0] C_32768   = 32'd32768;
	localparam logic [31:0] C_8192    = 32'd8192;
	localparam logic [31:0] C_ROUND_T = 32'd128;

	typedef enum logic [2:0] {
		REG_TEMP   = 3'd0,
		REG_PLOW   = 3'd1,
		REG_PHIGH  = 3'd2,
		REG_MIXED  = 3'd3,
		REG_HUM45  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] t1, t2, t3;
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6;
	} coef_t;

	typedef struct packed {
		logic [23:0] temp;
		logic [31:0] hq;
		logic        dbl;
		logic        zero;
	} tag_t;

	function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] s);
		return 32'($signed(x) >>> s);
	endfunction
endpackage

// File: rtl/csc_front.sv
`timescale 1ns / 1ps
module csc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  logic [19:0]         raw_temp,
	input  logic [19:0]         raw_press,
	input  logic [15:0]         raw_hum,
	input  csc_pkg::coef_t      cf,
	output logic                vout,
	output logic [31:0]         num,
	output logic [31:0]         dvs,
	output csc_pkg::tag_t       tag
);
	logic [12:1] v;
	logic [31:0] x1_s1, d_s1;
	logic [19:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7, ap_s8;
	logic [15:0] ah_s1, ah_s2, ah_s3, ah_s4, ah_s5, ah_s6;
	logic [31:0] at_s2, dd_s2, at_s3, b_s3, fine_s4;
	logic [23:0] tp_s5, tp_s6, tp_s7, tp_s8, tp_s9, tp_s10, tp_s11, tp_s12;
	logic [31:0] pa_s5, q_s5, hq_s5;
	logic [31:0] qq_s6, ap5_s6, ap2_s6, h5q_s6, hb_s6, hc_s6;
	logic [31:0] b_s7, ap5_s7, t3p_s7, ap2_s7, ha_s7, hb_s7, hc_s7;
	logic [31:0] bs_s8, pa2_s8, hbc_s8, ha_s8;
	logic [31:0] pa3_s9, pn_s9, hd_s9, ha_s9;
	logic [31:0] dv_s10, pn_s10, hd_s10, ha_s10;
	logic [31:0] dv_s11, num_s11, hd_s11, ha_s11;
	logic        dbl_s11, dbl_s12;
	logic [31:0] dv_s12, num_s12, hq_s12;
	logic [31:0] fine5;

	assign fine5 = (fine_s4 << 2) + fine_s4 + csc_pkg::C_ROUND_T;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (en) begin
			v <= {v[11:1], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= (32'(raw_temp) >> 3) - (cf.t1 << 1);
			d_s1 <= (32'(raw_temp) >> 4) - cf.t1;
			ap_s1 <= raw_press;
			ah_s1 <= raw_hum;

			at_s2 <= x1_s1 * cf.t2;
			dd_s2 <= d_s1 * d_s1;
			ap_s2 <= ap_s1;
			ah_s2 <= ah_s1;

			at_s3 <= csc_pkg::asr(at_s2, 5'd11);
			b_s3 <= csc_pkg::asr(dd_s2, 5'd12) * cf.t3;
			ap_s3 <= ap_s2;
			ah_s3 <= ah_s2;

			fine_s4 <= at_s3 + csc_pkg::asr(b_s3, 5'd14);
			ap_s4 <= ap_s3;
			ah_s4 <= ah_s3;

			tp_s5 <= 24'(csc_pkg::asr(fine5, 5'd8));
			pa_s5 <= csc_pkg::asr(fine_s4, 5'd1) - csc_pkg::C_64000;
			q_s5 <= csc_pkg::asr(csc_pkg::asr(fine_s4, 5'd1) - csc_pkg::C_64000, 5'd2);
			hq_s5 <= fine_s4 - csc_pkg::C_76800;
			ap_s5 <= ap_s4;
			ah_s5 <= ah_s4;

			qq_s6 <= q_s5 * q_s5;
			ap5_s6 <= pa_s5 * cf.p5;
			ap2_s6 <= cf.p2 * pa_s5;
			h5q_s6 <= cf.h5 * hq_s5;
			hb_s6 <= hq_s5 * cf.h6;
			hc_s6 <= hq_s5 * cf.h3;
			tp_s6 <= tp_s5;
			ap_s6 <= ap_s5;
			ah_s6 <= ah_s5;

			b_s7 <= csc_pkg::asr(qq_s6, 5'd11) * cf.p6;
			ap5_s7 <= ap5_s6;
			t3p_s7 <= cf.p3 * csc_pkg::asr(qq_s6, 5'd13);
			ap2_s7 <= ap2_s6;
			ha_s7 <= csc_pkg::asr((32'(ah_s6) << 14) - (cf.h4 << 20) - h5q_s6
				+ csc_pkg::C_16384, 5'd15);
			hb_s7 <= csc_pkg::asr(hb_s6, 5'd10);
			hc_s7 <= csc_pkg::asr(hc_s6, 5'd11) + csc_pkg::C_32768;
			tp_s7 <= tp_s6;
			ap_s7 <= ap_s6;

			bs_s8 <= csc_pkg::asr(b_s7 + (ap5_s7 << 1), 5'd2) + (cf.p4 << 16);
			pa2_s8 <= csc_pkg::asr(csc_pkg::asr(t3p_s7, 5'd3) + csc_pkg::asr(ap2_s7, 5'd1),
				5'd18);
			hbc_s8 <= hb_s7 * hc_s7;
			ha_s8 <= ha_s7;
			tp_s8 <= tp_s7;
			ap_s8 <= ap_s7;

			pa3_s9 <= (csc_pkg::C_32768 + pa2_s8) * cf.p1;
			pn_s9 <= (csc_pkg::C_1M - 32'(ap_s8)) - csc_pkg::asr(bs_s8, 5'd12);
			hd_s9 <= csc_pkg::asr(hbc_s8, 5'd10) + csc_pkg::C_2M;
			ha_s9 <= ha_s8;
			tp_s9 <= tp_s8;

			dv_s10 <= csc_pkg::asr(pa3_s9, 5'd15);
			pn_s10 <= pn_s9 * csc_pkg::C_3125;
			hd_s10 <= hd_s9 * cf.h2;
			ha_s10 <= ha_s9;
			tp_s10 <= tp_s9;

			dbl_s11 <= pn_s10 >= csc_pkg::C_SIGN;
			num_s11 <= (pn_s10 >= csc_pkg::C_SIGN) ? pn_s10 : (pn_s10 << 1);
			dv_s11 <= dv_s10;
			hd_s11 <= csc_pkg::asr(hd_s10 + csc_pkg::C_8192, 5'd14);
			ha_s11 <= ha_s10;
			tp_s11 <= tp_s10;

			hq_s12 <= ha_s11 * hd_s11;
			dbl_s12 <= dbl_s11;
			num_s12 <= num_s11;
			dv_s12 <= dv_s11;
			tp_s12 <= tp_s11;
		end
	end

	assign vout = v[12];
	assign num = num_s12;
	assign dvs = dv_s12;
	assign tag = '{temp: tp_s12, hq: hq_s12, dbl: dbl_s12, zero: (dv_s12 == '0)};
endmodule

// File: rtl/csc_div.sv
`timescale 1ns / 1ps
module csc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vin,
	input  logic [csc_pkg::DIV_W-1:0]  num,
	input  logic [csc_pkg::DIV_W-1:0]  dvs,
	input  csc_pkg::tag_t              tag_in,
	output logic                       vout,
	output logic [csc_pkg::DIV_W-1:0]  quo,
	output csc_pkg::tag_t              tag_out
);
	localparam int W = csc_pkg::DIV_W;

	logic [W-1:0]     v_s;
	logic [W-1:0]     rem_s [W];
	logic [W-1:0]     quo_s [W];
	logic [W-1:0]     num_s [W];
	logic [W-1:0]     dvs_s [W];
	csc_pkg::tag_t    tag_s [W];
	logic [W-1:0]     rem_in [W];
	logic [W-1:0]     quo_in [W];
	logic [W-1:0]     num_in [W];
	logic [W-1:0]     dvs_in [W];
	csc_pkg::tag_t    tag_i [W];
	logic [W:0]       trial [W];
	logic [W-1:0]     fit;

	always_comb begin
		rem_in[0] = '0;
		quo_in[0] = '0;
		num_in[0] = num;
		dvs_in[0] = dvs;
		tag_i[0] = tag_in;
		for (int k = 1; k < W; k++) begin
			rem_in[k] = rem_s[k-1];
			quo_in[k] = quo_s[k-1];
			num_in[k] = num_s[k-1];
			dvs_in[k] = dvs_s[k-1];
			tag_i[k] = tag_s[k-1];
		end
		for (int k = 0; k < W; k++) begin
			trial[k] = {rem_in[k], num_in[k][W-1]};
			fit[k] = trial[k] >= {1'b0, dvs_in[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[W-2:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < W; k++) begin
				rem_s[k] <= fit[k] ? W'(trial[k] - {1'b0, dvs_in[k]}) : trial[k][W-1:0];
				quo_s[k] <= {quo_in[k][W-2:0], fit[k]};
				num_s[k] <= num_in[k] << 1;
				dvs_s[k] <= dvs_in[k];
				tag_s[k] <= tag_i[k];
			end
		end
	end

	assign vout = v_s[W-1];
	assign quo = quo_s[W-1];
	assign tag_out = tag_s[W-1];
endmodule

// File: rtl/csc_back.sv
`timescale 1ns / 1ps
module csc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vin,
	input  logic [31:0]     quo,
	input  csc_pkg::tag_t   tag,
	input  csc_pkg::coef_t  cf,
	output logic            vout,
	output logic [23:0]     temp_centi,
	output logic [31:0]     press_pa,
	output logic            press_valid,
	output logic [16:0]     hum_q10
);
	logic [4:1]  v;
	logic [31:0] p_b1, sq_b1, hq_b1, p_b2, psq_b2, pd_b2, m_b2, hq_b2;
	logic [31:0] p_b3, c1_b3, d_b3, r_b3;
	logic [23:0] tp_b1, tp_b2, tp_b3;
	logic        z_b1, z_b2, z_b3;
	logic [31:0] qs, p_shr3, r_cl;

	assign qs = csc_pkg::asr(tag.hq, 5'd15);
	assign p_shr3 = p_b1 >> 3;
	assign r_cl = r_b3[31] ? '0 : ((r_b3 > csc_pkg::C_HUM_MAX) ? csc_pkg::C_HUM_MAX : r_b3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (en) begin
			v <= {v[3:1], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_b1 <= tag.dbl ? (quo << 1) : quo;
			sq_b1 <= qs * qs;
			hq_b1 <= tag.hq;
			tp_b1 <= tag.temp;
			z_b1 <= tag.zero;

			p_b2 <= p_b1;
			psq_b2 <= p_shr3 * p_shr3;
			pd_b2 <= (p_b1 >> 2) * cf.p8;
			m_b2 <= csc_pkg::asr(sq_b1, 5'd7) * cf.h1;
			hq_b2 <= hq_b1;
			tp_b2 <= tp_b1;
			z_b2 <= z_b1;

			p_b3 <= p_b2;
			c1_b3 <= cf.p9 * (psq_b2 >> 13);
			d_b3 <= csc_pkg::asr(pd_b2, 5'd13);
			r_b3 <= hq_b2 - csc_pkg::asr(m_b2, 5'd4);
			tp_b3 <= tp_b2;
			z_b3 <= z_b2;

			press_pa <= z_b3 ? '0
				: p_b3 + csc_pkg::asr(csc_pkg::asr(c1_b3, 5'd12) + d_b3 + cf.p7, 5'd4);
			press_valid <= !z_b3;
			hum_q10 <= r_cl[28:12];
			temp_centi <= tp_b3;
		end
	end

	assign vout = v[4];
endmodule

// File: rtl/climate_sensor_compensation.sv
`timescale 1ns / 1ps
// Integer compensation of raw temperature, pressure and humidity readings.
// Input beat on s_*: s_tdata = raw_temp, raw_press, raw_hum (lowest bit up).
// Output beat on m_*: m_tdata = temp_centi, press_pa, hum_q10; m_tuser =
// press_valid, low when the pressure divisor is zero (press_pa is then 0).
// Calibration coefficients are written over the APB port, 64-bit registers
// at byte addresses 0, 8, 16, 24, 32; write them only while no beat is in
// flight. Reads return the stored values.
// An input beat passes to the output beat through 12 front stages,
// a 32-stage restoring divider (one quotient bit per stage) and 4 back
// stages. One beat is accepted every cycle while the output is taken.
// When m_tready is low with a beat waiting, the whole pipe holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all coefficients and every stage valid bit.
`include "climate_sensor_compensation_defines.svh"
module climate_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // raw_temp, raw_press, raw_hum
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // temp_centi, press_pa, hum_q10, zero pad
	output logic [0:0]  m_tuser,   // press_valid
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	logic [47:0] temp_q;
	logic [63:0] plow_q, phigh_q;
	logic [55:0] mixed_q;
	logic [31:0] hum45_q;
	csc_pkg::coef_t cf;
	csc_pkg::reg_idx_t idx;
	logic en, f_v, d_v;
	logic [31:0] f_num, f_dvs, d_quo;
	csc_pkg::tag_t f_tag, d_tag;
	logic [23:0] temp_centi;
	logic [31:0] press_pa;
	logic        press_valid;
	logic [16:0] hum_q10;

	assign pready = 1'b1;
	assign idx = csc_pkg::reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			plow_q <= '0;
			phigh_q <= '0;
			mixed_q <= '0;
			hum45_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				csc_pkg::REG_TEMP:  temp_q <= pwdata[47:0];
				csc_pkg::REG_PLOW:  plow_q <= pwdata;
				csc_pkg::REG_PHIGH: phigh_q <= pwdata;
				csc_pkg::REG_MIXED: mixed_q <= pwdata[55:0];
				csc_pkg::REG_HUM45: hum45_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			csc_pkg::REG_TEMP:  prdata = 64'(temp_q);
			csc_pkg::REG_PLOW:  prdata = plow_q;
			csc_pkg::REG_PHIGH: prdata = phigh_q;
			csc_pkg::REG_MIXED: prdata = 64'(mixed_q);
			csc_pkg::REG_HUM45: prdata = 64'(hum45_q);
			default:            prdata = '0;
		endcase
	end

	assign cf.t1 = {16'b0, temp_q[15:0]};
	assign cf.t2 = {{16{temp_q[31]}}, temp_q[31:16]};
	assign cf.t3 = {{16{temp_q[47]}}, temp_q[47:32]};
	assign cf.p1 = {16'b0, plow_q[15:0]};
	assign cf.p2 = {{16{plow_q[31]}}, plow_q[31:16]};
	assign cf.p3 = {{16{plow_q[47]}}, plow_q[47:32]};
	assign cf.p4 = {{16{plow_q[63]}}, plow_q[63:48]};
	assign cf.p5 = {{16{phigh_q[15]}}, phigh_q[15:0]};
	assign cf.p6 = {{16{phigh_q[31]}}, phigh_q[31:16]};
	assign cf.p7 = {{16{phigh_q[47]}}, phigh_q[47:32]};
	assign cf.p8 = {{16{phigh_q[63]}}, phigh_q[63:48]};
	assign cf.p9 = {{16{mixed_q[15]}}, mixed_q[15:0]};
	assign cf.h1 = {24'b0, mixed_q[23:16]};
	assign cf.h2 = {{16{mixed_q[39]}}, mixed_q[39:24]};
	assign cf.h3 = {24'b0, mixed_q[47:40]};
	assign cf.h6 = {{24{mixed_q[55]}}, mixed_q[55:48]};
	assign cf.h4 = {{16{hum45_q[15]}}, hum45_q[15:0]};
	assign cf.h5 = {{16{hum45_q[31]}}, hum45_q[31:16]};

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	csc_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(s_tvalid && s_tready),
		.raw_temp(s_tdata[19:0]), .raw_press(s_tdata[39:20]), .raw_hum(s_tdata[55:40]),
		.cf(cf), .vout(f_v), .num(f_num), .dvs(f_dvs), .tag(f_tag)
	);

	csc_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(f_v), .num(f_num), .dvs(f_dvs),
		.tag_in(f_tag), .vout(d_v), .quo(d_quo), .tag_out(d_tag)
	);

	csc_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(d_v), .quo(d_quo), .tag(d_tag),
		.cf(cf), .vout(m_tvalid), .temp_centi(temp_centi), .press_pa(press_pa),
		.press_valid(press_valid), .hum_q10(hum_q10)
	);

	assign m_tdata = {7'b0, hum_q10, press_pa, temp_centi};
	assign m_tuser = press_valid;

	`CSC_ASSERT_NOW(a_zero_press, m_tvalid && !m_tuser[0], m_tdata[55:24] == 32'd0)
	`CSC_ASSERT_NOW(a_hum_range, m_tvalid, m_tdata[72:56] <= 17'd102400)
	`CSC_ASSERT_NOW(a_ready, 1'b1, s_tready == (!m_tvalid || m_tready))
	`CSC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
